>>> rtl/core/smpp_pkg.sv
package smpp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned DeltaW = 10;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned OutW   = 24;

  typedef enum logic [ModeW-1:0] {
    MODE_PC   = 2'd0,
    MODE_MS   = 2'd1,
    MODE_PS2  = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  localparam mode_e ModeReset = MODE_MS;

  typedef struct packed {
    logic              button_right;
    logic              button_middle;
    logic              button_left;
    logic [DeltaW-1:0] delta_y;
    logic [DeltaW-1:0] delta_x;
  } result_t;

  function automatic logic [DeltaW-1:0] sext8(input logic [ByteW-1:0] b);
    sext8 = {{(DeltaW - ByteW){b[ByteW-1]}}, b};
  endfunction

endpackage

>>> rtl/core/smpp_decode.sv
module smpp_decode
  import smpp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  mode_e            mode_i,
  input  logic             step_i,
  input  logic [ByteW-1:0] byte_i,
  output logic             res_valid_o,
  output result_t          res_o
);

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_XSET = 3'd1,
    PH_YSET = 3'd2,
    PH_XADD = 3'd3,
    PH_YADD = 3'd4
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [DeltaW-1:0] x_q, x_d, y_q, y_d;
  logic [2:0]        btn_q, btn_d;
  logic [DeltaW-1:0] sx;
  logic [ByteW-1:0]  y_merge;

  assign sx      = sext8(byte_i);
  assign y_merge = {y_q[7:6], byte_i[5:0]};

  always_comb begin
    phase_d     = phase_q;
    x_d         = x_q;
    y_d         = y_q;
    btn_d       = btn_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    unique case (mode_i)
      MODE_PC: begin
        unique case (phase_q)
          PH_IDLE: begin
            if (byte_i[7:3] == 5'b10000) begin
              btn_d   = ~byte_i[2:0];
              phase_d = PH_XSET;
            end
          end
          PH_XSET: begin
            x_d     = sx;
            phase_d = PH_YSET;
          end
          PH_YSET: begin
            y_d     = -sx;
            phase_d = PH_XADD;
          end
          PH_XADD: begin
            x_d     = x_q + sx;
            phase_d = PH_YADD;
          end
          PH_YADD: begin
            y_d         = y_q - sx;
            phase_d     = PH_IDLE;
            res_valid_o = 1'b1;
            res_o       = '{button_right: btn_q[0], button_middle: btn_q[1],
                            button_left: btn_q[2], delta_y: y_d, delta_x: x_q};
          end
          default: phase_d = PH_IDLE;
        endcase
      end
      MODE_MS: begin
        unique case (phase_q)
          PH_IDLE: begin
            if (byte_i[6]) begin
              btn_d   = {1'b0, byte_i[5:4]};
              y_d     = {2'b0, byte_i[3:2], 6'b0};
              x_d     = {2'b0, byte_i[1:0], 6'b0};
              phase_d = PH_XADD;
            end
          end
          PH_XADD: begin
            x_d     = {2'b0, x_q[7:6], byte_i[5:0]};
            phase_d = PH_YADD;
          end
          PH_YADD: begin
            x_d         = sext8(x_q[7:0]);
            y_d         = sext8(y_merge);
            phase_d     = PH_IDLE;
            res_valid_o = 1'b1;
            res_o       = '{button_right: btn_q[0], button_middle: 1'b0,
                            button_left: btn_q[1], delta_y: y_d, delta_x: x_d};
          end
          default: phase_d = PH_IDLE;
        endcase
      end
      MODE_PS2: begin
        unique case (phase_q)
          PH_IDLE: begin
            if (byte_i[3]) begin
              btn_d   = {1'b0, byte_i[1:0]};
              phase_d = PH_XSET;
            end
          end
          PH_XSET: begin
            x_d     = sx;
            phase_d = PH_YSET;
          end
          PH_YSET: begin
            y_d         = -sx;
            phase_d     = PH_IDLE;
            res_valid_o = 1'b1;
            res_o       = '{button_right: btn_q[1], button_middle: 1'b0,
                            button_left: btn_q[0], delta_y: y_d, delta_x: x_q};
          end
          default: phase_d = PH_IDLE;
        endcase
      end
      default: begin
      end
    endcase
    if (!step_i) begin
      res_valid_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      x_q     <= '0;
      y_q     <= '0;
      btn_q   <= '0;
    end else if (cfg_we_i) begin
      phase_q <= PH_IDLE;
    end else if (step_i) begin
      phase_q <= phase_d;
      x_q     <= x_d;
      y_q     <= y_d;
      btn_q   <= btn_d;
    end
  end

endmodule

>>> rtl/core/smpp_out_reg.sv
module smpp_out_reg
  import smpp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  input  logic    ready_i,
  output logic    free_o,
  output logic    valid_o,
  output result_t res_o
);

  logic    valid_q;
  result_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      res_q <= res_i;
    end
  end

endmodule

>>> rtl/core/serial_mouse_packet_parser.sv
// Channel  Direction  Width  Contents
// s_axis   in         8      rx_byte
// m_axis   out        24     delta_x, delta_y, buttons
// cfg      in         2      protocol_mode
//
// A byte is taken into an input register and decoded from there; a finished
// report is loaded into the output register, from which it is valid on m_axis
// until it is taken.
// One byte is taken per cycle; the input register and the output register
// stall together only when a report waits and m_axis_tready is low.
// Reset clears the parser to idle and sets the mode to three-byte serial.
module serial_mouse_packet_parser
  import smpp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [ModeW-1:0] cfg_wdata_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [ByteW-1:0] s_axis_tdata,   // [7:0] rx_byte
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OutW-1:0]  m_axis_tdata    // [9:0] delta_x, [19:10] delta_y,
                                           // [20] left, [21] middle, [22] right
);

  mode_e            mode_q;
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             step;
  logic             out_free;
  logic             res_valid;
  result_t          res;
  result_t          out_res;

  assign step          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= ModeReset;
      in_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= mode_e'(cfg_wdata_i);
      end
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  smpp_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .mode_i     (mode_q),
    .step_i     (step),
    .byte_i     (in_byte_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  smpp_out_reg u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (res_valid),
    .res_i  (res),
    .ready_i(m_axis_tready),
    .free_o (out_free),
    .valid_o(m_axis_tvalid),
    .res_o  (out_res)
  );

  assign m_axis_tdata = {1'b0, out_res};

endmodule

>>> rtl/core/smpp_checker.sv
module smpp_checker
  import smpp_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OutW-1:0]  m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Report changed while stalled.");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("Input stalled without a waiting report.");

  a_ready_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("Input stalled while the output drains.");

  a_report_needs_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready || s_axis_tvalid, 2)
                             || $past(!s_axis_tready, 1))
    else $error("Report appeared without a byte transfer.");

endmodule

bind serial_mouse_packet_parser smpp_checker u_smpp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

>>> test/tb.sv
import smpp_pkg::*;

typedef enum logic [2:0] {
  PARSE_IDLE,
  PARSE_X_FIRST,
  PARSE_Y_FIRST,
  PARSE_X_ADD,
  PARSE_Y_ADD
} parse_phase_e;

class mouse_report_board;
  mode_e                    mode;
  parse_phase_e             phase;
  logic signed [DeltaW-1:0] x_acc;
  logic signed [DeltaW-1:0] y_acc;
  logic [2:0]               btn_bits;
  result_t                  expected_reports[$];
  int                       errors;

  function new();
    mode     = ModeReset;
    phase    = PARSE_IDLE;
    x_acc    = '0;
    y_acc    = '0;
    btn_bits = '0;
    errors   = 0;
  endfunction

  function void set_mode(mode_e m);
    mode  = m;
    phase = PARSE_IDLE;
  endfunction

  function int pending();
    return expected_reports.size();
  endfunction

  function void note_byte(logic [ByteW-1:0] b);
    logic signed [DeltaW-1:0] v;
    logic                     done;
    result_t                  r;
    v    = DeltaW'(signed'(b));
    done = 1'b0;
    r    = '0;
    case (mode)
      MODE_PC: begin
        case (phase)
          PARSE_IDLE: begin
            if ((b & 8'hF8) == 8'h80) begin
              btn_bits = ~b[2:0];
              phase    = PARSE_X_FIRST;
            end
          end
          PARSE_X_FIRST: begin
            x_acc = v;
            phase = PARSE_Y_FIRST;
          end
          PARSE_Y_FIRST: begin
            y_acc = -v;
            phase = PARSE_X_ADD;
          end
          PARSE_X_ADD: begin
            x_acc = x_acc + v;
            phase = PARSE_Y_ADD;
          end
          PARSE_Y_ADD: begin
            y_acc           = y_acc - v;
            phase           = PARSE_IDLE;
            done            = 1'b1;
            r.button_left   = btn_bits[2];
            r.button_middle = btn_bits[1];
            r.button_right  = btn_bits[0];
          end
          default: phase = PARSE_IDLE;
        endcase
      end
      MODE_MS: begin
        case (phase)
          PARSE_IDLE: begin
            if (b[6]) begin
              btn_bits = {1'b0, b[5:4]};
              y_acc    = {2'b00, b[3:2], 6'b000000};
              x_acc    = {2'b00, b[1:0], 6'b000000};
              phase    = PARSE_X_ADD;
            end
          end
          PARSE_X_ADD: begin
            x_acc = {2'b00, x_acc[7:6], b[5:0]};
            phase = PARSE_Y_ADD;
          end
          PARSE_Y_ADD: begin
            y_acc          = {2'b00, y_acc[7:6], b[5:0]};
            x_acc          = DeltaW'(signed'(x_acc[7:0]));
            y_acc          = DeltaW'(signed'(y_acc[7:0]));
            phase          = PARSE_IDLE;
            done           = 1'b1;
            r.button_left  = btn_bits[1];
            r.button_right = btn_bits[0];
          end
          default: phase = PARSE_IDLE;
        endcase
      end
      MODE_PS2: begin
        case (phase)
          PARSE_IDLE: begin
            if (b[3]) begin
              btn_bits = {1'b0, b[1:0]};
              phase    = PARSE_X_FIRST;
            end
          end
          PARSE_X_FIRST: begin
            x_acc = v;
            phase = PARSE_Y_FIRST;
          end
          PARSE_Y_FIRST: begin
            y_acc          = -v;
            phase          = PARSE_IDLE;
            done           = 1'b1;
            r.button_left  = btn_bits[0];
            r.button_right = btn_bits[1];
          end
          default: phase = PARSE_IDLE;
        endcase
      end
      default: ;
    endcase
    if (done) begin
      r.delta_x = x_acc;
      r.delta_y = y_acc;
      expected_reports.push_back(r);
    end
  endfunction

  function void check_report(logic [OutW-1:0] data);
    result_t got;
    result_t want;
    got = result_t'(data[$bits(result_t)-1:0]);
    if (expected_reports.size() == 0) begin
      errors++;
      if (errors <= 10) begin
        $display("%0t: unexpected report x=%0d y=%0d l=%0b m=%0b r=%0b", $time,
                 $signed(got.delta_x), $signed(got.delta_y), got.button_left,
                 got.button_middle, got.button_right);
      end
    end else begin
      want = expected_reports.pop_front();
      if (got.delta_x !== want.delta_x || got.delta_y !== want.delta_y ||
          got.button_left !== want.button_left ||
          got.button_middle !== want.button_middle ||
          got.button_right !== want.button_right) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: report expected x=%0d y=%0d l=%0b m=%0b r=%0b", $time,
                   $signed(want.delta_x), $signed(want.delta_y), want.button_left,
                   want.button_middle, want.button_right);
          $display("%0t:        actual x=%0d y=%0d l=%0b m=%0b r=%0b", $time,
                   $signed(got.delta_x), $signed(got.delta_y), got.button_left,
                   got.button_middle, got.button_right);
        end
      end
    end
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QuietLimit = 1000;
  localparam int HoldCycles = 64;

  localparam logic [7:0] MsDirected [7] = '{
    8'h00, 8'h7F, 8'h3F, 8'h3F, 8'h40, 8'h00, 8'h00
  };
  localparam logic [7:0] PcDirected [11] = '{
    8'h7F, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h87, 8'h7F, 8'h7F, 8'h7F, 8'h7F
  };
  localparam logic [7:0] Ps2Directed [6] = '{
    8'h07, 8'h0B, 8'h80, 8'h80, 8'h09, 8'h05
  };
  localparam logic [7:0] Extremes [4] = '{8'h00, 8'h7F, 8'h80, 8'hFF};
  localparam mode_e PhaseModes [9] = '{
    MODE_PC, MODE_PS2, MODE_MS, MODE_NONE, MODE_PC, MODE_MS, MODE_PS2, MODE_PC, MODE_MS
  };

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [ModeW-1:0] cfg_wdata_i;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [ByteW-1:0] s_axis_tdata;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OutW-1:0]  m_axis_tdata;

  mouse_report_board reports = new();
  logic              idle_on = 1'b1;
  logic              stall_request = 1'b0;
  int                quiet_cycles = 0;

  serial_mouse_packet_parser DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      reports.check_report(m_axis_tdata);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // The long hold lets the report path fill up so that the input side stalls.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_request) begin
        stall_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 2)) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    reports.note_byte(b);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (reports.pending() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_mode(input mode_e m);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    reports.set_mode(m);
  endtask

  task automatic send_packet(input mode_e m, output int sent);
    logic [7:0] head;
    logic [7:0] payload;
    int         len;
    case (m)
      MODE_PC: begin
        head = 8'h80 | 8'($urandom_range(0, 7));
        len  = 5;
      end
      MODE_MS: begin
        head = 8'($urandom) | 8'h40;
        len  = 3;
      end
      MODE_PS2: begin
        head = 8'($urandom) | 8'h08;
        len  = 3;
      end
      default: begin
        head = 8'($urandom);
        len  = 1;
      end
    endcase
    if ($urandom_range(0, 7) == 0) begin
      head = 8'($urandom);
      len  = 1;
    end else if (len > 1 && $urandom_range(0, 15) == 0) begin
      len = $urandom_range(1, len - 1);
    end
    send_byte(head);
    for (int i = 1; i < len; i++) begin
      payload = ($urandom_range(0, 3) == 0) ? Extremes[$urandom_range(0, 3)] : 8'($urandom);
      send_byte(payload);
    end
    sent = len;
  endtask

  initial begin
    int sent;
    int phase_bytes;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = ModeReset;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (MsDirected[i]) send_byte(MsDirected[i]);
    write_mode(MODE_PC);
    foreach (PcDirected[i]) send_byte(PcDirected[i]);
    write_mode(MODE_PS2);
    foreach (Ps2Directed[i]) send_byte(Ps2Directed[i]);
    // The packet left open above is dropped by the mode change.
    write_mode(MODE_NONE);
    send_byte(8'hFF);
    send_byte(8'h80);

    for (int p = 0; p < 9; p++) begin
      idle_on = (p < 7);
      write_mode(PhaseModes[p]);
      if (p == 1) begin
        stall_request = 1'b1;
      end
      phase_bytes = 0;
      while (phase_bytes < ((PhaseModes[p] == MODE_NONE) ? 12 : 57)) begin
        send_packet(PhaseModes[p], sent);
        phase_bytes += sent;
      end
    end

    drain();
    if (reports.errors == 0 && reports.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
